// ----- hw/rtl/rrqs_pkg.sv -----
package rrqs_pkg;

	// Ready queue geometry.
	localparam int QUEUE_DEPTH = 16;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// Field widths fixed by the interface.
	localparam int ID_W    = 8;
	localparam int BURST_W = 16;
	localparam int SLICE_W = 8;
	localparam int OCC_W   = 5;

	localparam logic [SLICE_W-1:0] TIME_SLICE_RESET = 8'd10;

	localparam logic MODE_ADD      = 1'b0;
	localparam logic MODE_DISPATCH = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	// Per-cell control: load the given task, or take the neighbor's task.
	typedef struct packed {
		logic               shift;
		logic               load;
		logic [ID_W-1:0]    id;
		logic [BURST_W-1:0] burst;
	} cell_ctrl_t;

endpackage

// ----- hw/rtl/round_robin_quantum_scheduler_unit.sv -----
// Round-robin time-slice scheduler. Tasks wait in a ready queue built as a
// row of QUEUE_DEPTH cells; cell 0 always holds the task at the head, and
// the queue tail is the cell just past the last occupied one. An add word
// writes its task straight into the tail cell, or is rejected with status
// full when every cell is taken. A dispatch word grants the head task the
// smaller of the time slice and its remaining burst; every cell then takes
// its upper neighbor's task, so the queue moves one place toward the head,
// and a task with burst left is written back into the new tail cell in the
// same cycle. A dispatch on an empty queue reports status empty. Each input
// word yields exactly one result word. An accepted word's result is loaded
// into the output register on the next clock edge; a new word is taken
// every cycle while the output register is empty or being drained, so the
// rate is one word per cycle, set by the head-cell read, the grant compare
// and subtract, and the cell update that all fall in the same cycle. A time
// slice of zero is treated as one. The time slice register is written
// through cfg_we and cfg_wdata and resets to ten.
module round_robin_quantum_scheduler_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [rrqs_pkg::SLICE_W-1:0] cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         mode,
	input  logic [rrqs_pkg::ID_W-1:0]    task_id,
	input  logic [rrqs_pkg::BURST_W-1:0] task_burst,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [rrqs_pkg::ID_W-1:0]    run_id,
	output logic [rrqs_pkg::SLICE_W-1:0] run_time,
	output logic [rrqs_pkg::BURST_W-1:0] remaining,
	output logic                         finished,
	output logic [1:0]                   status,
	output logic [rrqs_pkg::OCC_W-1:0]   occupancy
);
	import rrqs_pkg::*;

	// Configuration and queue bookkeeping.
	logic [SLICE_W-1:0] time_slice_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_d;

	// Result register.
	logic               out_valid_q;
	logic [ID_W-1:0]    run_id_q;
	logic [SLICE_W-1:0] run_time_q;
	logic [BURST_W-1:0] remaining_q;
	logic               finished_q;
	status_t            status_q;

	// Cell row.
	cell_ctrl_t         ctrl   [QUEUE_DEPTH];
	logic [ID_W-1:0]    cell_id    [QUEUE_DEPTH];
	logic [BURST_W-1:0] cell_burst [QUEUE_DEPTH];

	// Decode of the current word.
	logic               accept;
	logic               empty;
	logic               full;
	logic [SLICE_W-1:0] quantum;
	logic [SLICE_W-1:0] grant;
	logic [BURST_W-1:0] rem;
	logic               do_add;
	logic               do_disp;
	logic               requeue;
	logic [CNT_W-1:0]   load_slot;
	logic [ID_W-1:0]    load_id;
	logic [BURST_W-1:0] load_burst;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign empty    = (count_q == '0);
	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));

	assign quantum = (time_slice_q == '0) ? SLICE_W'(1) : time_slice_q;
	assign grant   = (cell_burst[0] < {{(BURST_W-SLICE_W){1'b0}}, quantum})
		? cell_burst[0][SLICE_W-1:0] : quantum;
	assign rem     = cell_burst[0] - {{(BURST_W-SLICE_W){1'b0}}, grant};

	assign do_add  = accept && (mode == MODE_ADD) && !full;
	assign do_disp = accept && (mode == MODE_DISPATCH) && !empty;
	assign requeue = do_disp && (rem != '0);

	// An unfinished task lands in the cell the last task leaves in the shift; an added task lands in the tail cell.
	always_comb begin
		if (mode == MODE_ADD) begin
			load_slot  = count_q;
			load_id    = task_id;
			load_burst = task_burst;
		end else begin
			load_slot  = count_q - CNT_W'(1);
			load_id    = cell_id[0];
			load_burst = rem;
		end
	end

	always_comb begin
		count_d = count_q;
		if (do_add) begin
			count_d = count_q + CNT_W'(1);
		end else if (do_disp && !requeue) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	generate
		for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
			logic [ID_W-1:0]    nbr_id;
			logic [BURST_W-1:0] nbr_burst;

			if (i == QUEUE_DEPTH - 1) begin : g_last
				assign nbr_id    = '0;
				assign nbr_burst = '0;
			end else begin : g_mid
				assign nbr_id    = cell_id[i+1];
				assign nbr_burst = cell_burst[i+1];
			end

			always_comb begin
				ctrl[i].shift = do_disp;
				ctrl[i].load  = (do_add || requeue) && (load_slot == CNT_W'(i));
				ctrl[i].id    = load_id;
				ctrl[i].burst = load_burst;
			end

			rrqs_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl[i]),
				.nbr_id    (nbr_id),
				.nbr_burst (nbr_burst),
				.id        (cell_id[i]),
				.burst     (cell_burst[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_slice_q <= TIME_SLICE_RESET;
		end else if (cfg_we) begin
			time_slice_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload; fields other than status and occupancy are zero unless
	// a task was actually dispatched.
	always_ff @(posedge clk) begin
		if (accept) begin
			run_id_q    <= do_disp ? cell_id[0] : '0;
			run_time_q  <= do_disp ? grant : '0;
			remaining_q <= do_disp ? rem : '0;
			finished_q  <= do_disp && !requeue;
			if (mode == MODE_ADD) begin
				status_q <= full ? STATUS_FULL : STATUS_OK;
			end else begin
				status_q <= empty ? STATUS_EMPTY : STATUS_OK;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign run_id    = run_id_q;
	assign run_time  = run_time_q;
	assign remaining = remaining_q;
	assign finished  = finished_q;
	assign status    = status_q;
	assign occupancy = OCC_W'(count_q);

	// The queue never holds more tasks than it has cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count exceeds depth");

	// An accepted word always produces a result on the next edge.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted word produced no result");

	// A full status is only shown while the queue is full.
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == STATUS_FULL) |-> (count_q == CNT_W'(QUEUE_DEPTH)))
		else $error("full status with queue not full");

	// A retired task has no burst left and was dispatched successfully.
	a_finished: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && finished_q) |-> (remaining_q == '0 && status_q == STATUS_OK))
		else $error("finished task with burst left");

endmodule

// ----- hw/rtl/rrqs_cell.sv -----
module rrqs_cell (
	input  logic                         clk,
	input  rrqs_pkg::cell_ctrl_t         ctrl,
	input  logic [rrqs_pkg::ID_W-1:0]    nbr_id,
	input  logic [rrqs_pkg::BURST_W-1:0] nbr_burst,
	output logic [rrqs_pkg::ID_W-1:0]    id,
	output logic [rrqs_pkg::BURST_W-1:0] burst
);
	import rrqs_pkg::*;

	logic [ID_W-1:0]    id_q;
	logic [BURST_W-1:0] burst_q;

	// A direct load wins over the shift, so the tail slot takes the new task.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			id_q    <= ctrl.id;
			burst_q <= ctrl.burst;
		end else if (ctrl.shift) begin
			id_q    <= nbr_id;
			burst_q <= nbr_burst;
		end
	end

	assign id    = id_q;
	assign burst = burst_q;

endmodule
